>>> hdl/rra_pkg.sv
// Shared types, constants and codes for the region-restricted autocorrelation block.
package rra_pkg;

   localparam int MaxFrames = 1024;
   localparam int AddrW     = 10;
   localparam int FillW     = 11;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] CSR_STRIDE = 3'd0;
   localparam logic [2:0] CSR_LO_MIN = 3'd1;
   localparam logic [2:0] CSR_LO_MAX = 3'd2;
   localparam logic [2:0] CSR_UP_MIN = 3'd3;
   localparam logic [2:0] CSR_UP_MAX = 3'd4;

   localparam logic KIND_FINISH = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Command that the front end hands to the back end.
   typedef struct packed {
      logic [1:0]       op;
      logic [AddrW-1:0] lag;
      logic [FillW-1:0] frames;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] lo_min;
      logic signed [15:0] lo_max;
      logic signed [15:0] up_min;
      logic signed [15:0] up_max;
      logic [10:0]        stride;
   } cfg_type;

endpackage

>>> hdl/rra_front.sv
// Front end: frame stores, load handling, and command queue toward the back end.
module rra_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic signed [15:0]            req_mu_x,
   input  logic signed [15:0]            req_mu_y,
   input  logic signed [15:0]            req_mu_z,
   input  logic signed [15:0]            req_height,
   input  logic [9:0]                    req_read_lag,
   output logic                          cmd_valid,
   output rra_pkg::cmd_type              cmd,
   input  logic                          cmd_pop,
   input  logic                          walking,
   input  logic [rra_pkg::AddrW-1:0]     rd_addr_a,
   input  logic [rra_pkg::AddrW-1:0]     rd_addr_b,
   output logic [47:0]                   rd_dip_a,
   output logic [47:0]                   rd_dip_b,
   output logic signed [15:0]            rd_hgt_b
);

   logic [47:0]              dip_mem [rra_pkg::MaxFrames];
   logic [15:0]              hgt_mem [rra_pkg::MaxFrames];
   logic [rra_pkg::FillW-1:0] fill_ff, fill_in;
   logic                     q_valid_ff, q_valid_in;
   rra_pkg::cmd_type         q_ff, q_in;
   logic                     accept;
   logic                     do_load;

   // hold off beats while a command waits or the back end reads the frames
   assign busy    = q_valid_ff || walking;
   assign accept  = req_start && !busy;
   assign do_load = accept && (req_op == rra_pkg::OP_LOAD)
                    && (fill_ff < rra_pkg::FillW'(rra_pkg::MaxFrames));

   always_comb begin
      fill_in    = fill_ff;
      q_valid_in = q_valid_ff && !cmd_pop;
      q_in       = q_ff;
      if (do_load) begin
         fill_in = fill_ff + 1'b1;
      end
      if (accept && req_op != rra_pkg::OP_LOAD) begin
         q_valid_in = 1'b1;
         q_in.op     = req_op;
         q_in.lag    = req_read_lag;
         q_in.frames = fill_ff;
         if (req_op == rra_pkg::OP_FINISH) begin
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         q_valid_ff <= q_valid_in;
      end
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         dip_mem[fill_ff[rra_pkg::AddrW-1:0]] <= {req_mu_x, req_mu_y, req_mu_z};
         hgt_mem[fill_ff[rra_pkg::AddrW-1:0]] <= req_height;
      end
      rd_dip_a <= dip_mem[rd_addr_a];
      rd_dip_b <= dip_mem[rd_addr_b];
      rd_hgt_b <= hgt_mem[rd_addr_b];
   end

   assign cmd_valid = q_valid_ff;
   assign cmd       = q_ff;

endmodule

>>> hdl/rra_divider.sv
// Restoring signed divider, one quotient bit per cycle, 64-bit by 32-bit.
module rra_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic [31:0]        divisor,
   output logic               done,
   output logic signed [63:0] quotient
);

   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [63:0] q_out;

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {r_ff[31:0], q_ff[63]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = 7'd64;
         neg_in = dividend[63];
         q_in   = dividend[63] ? 64'(-dividend) : 64'(dividend);
         r_in   = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         q_in = {q_ff[62:0], 1'b0};
         if (shifted >= {1'b0, d_ff}) begin
            r_in  = shifted - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = shifted;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign q_out    = neg_ff ? 64'(-q_ff) : q_ff;
   assign done     = done_ff;
   assign quotient = signed'(q_out);

endmodule

>>> hdl/rra_back.sv
// Back end: origin and lag walk, lag accumulators, clear sweep and lag reads.
module rra_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  rra_pkg::cmd_type           cmd,
   output logic                       cmd_pop,
   output logic                       walking,
   input  rra_pkg::cfg_type           cfg,
   output logic [rra_pkg::AddrW-1:0]  rd_addr_a,
   output logic [rra_pkg::AddrW-1:0]  rd_addr_b,
   input  logic [47:0]                rd_dip_a,
   input  logic [47:0]                rd_dip_b,
   input  logic signed [15:0]         rd_hgt_b,
   output logic                       rsp_strobe,
   output logic                       rsp_kind,
   output logic [9:0]                 rsp_lag_echo,
   output logic signed [31:0]         rsp_average,
   output logic [31:0]                rsp_sample_total
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ORIG   = 4'd1;
   localparam logic [3:0] S_OWAIT  = 4'd2;
   localparam logic [3:0] S_OCHK   = 4'd3;
   localparam logic [3:0] S_LAG    = 4'd4;
   localparam logic [3:0] S_LWAIT  = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_SUM    = 4'd7;
   localparam logic [3:0] S_ACC    = 4'd8;
   localparam logic [3:0] S_CLR    = 4'd9;
   localparam logic [3:0] S_RD     = 4'd10;
   localparam logic [3:0] S_RWAIT  = 4'd11;
   localparam logic [3:0] S_DIV    = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;

   logic [63:0] sum_mem [rra_pkg::MaxFrames];
   logic [31:0] cnt_mem [rra_pkg::MaxFrames];

   logic [3:0]                st_ff, st_in;
   logic [rra_pkg::FillW-1:0] n_ff, n_in;
   logic [rra_pkg::FillW-1:0] i_ff, i_in;
   logic [rra_pkg::FillW-1:0] k_ff, k_in;
   logic                      olow_ff, olow_in, oup_ff, oup_in;
   logic [9:0]                lag_ff, lag_in;
   logic signed [31:0]        px_ff, py_ff, pz_ff;
   logic signed [33:0]        dot_ff;
   logic [63:0]               rs_ff;
   logic [31:0]               rc_ff;
   logic                      mem_rd;
   logic [9:0]                mem_addr;
   logic                      mem_we;
   logic [63:0]               mem_wsum;
   logic [31:0]               mem_wcnt;
   logic                      div_start;
   logic                      div_done;
   logic signed [63:0]        div_q;
   logic                      strobe_ff, strobe_in;
   logic                      kind_ff, kind_in;
   logic [9:0]                echo_ff, echo_in;
   logic signed [31:0]        avg_ff, avg_in;
   logic [31:0]               tot_ff, tot_in;
   logic [rra_pkg::FillW-1:0] stride;
   logic                      hlow, hup;
   logic [rra_pkg::FillW-1:0] i_next;
   logic signed [64:0]        wide_sum;

   assign stride = (cfg.stride == '0) ? rra_pkg::FillW'(1) : cfg.stride;
   assign hlow   = (rd_hgt_b >= cfg.lo_min) && (rd_hgt_b <= cfg.lo_max);
   assign hup    = (rd_hgt_b >= cfg.up_min) && (rd_hgt_b <= cfg.up_max);
   assign i_next = i_ff + stride;
   assign rd_addr_a = i_ff[rra_pkg::AddrW-1:0];
   assign rd_addr_b = (st_ff == S_ORIG || st_ff == S_OWAIT) ? i_ff[rra_pkg::AddrW-1:0]
                                                             : k_ff[rra_pkg::AddrW-1:0];
   assign wide_sum  = {rs_ff[63], rs_ff} + 65'(dot_ff);
   assign walking   = (st_ff >= S_ORIG) && (st_ff <= S_ACC);

   always_comb begin
      st_in     = st_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      olow_in   = olow_ff;
      oup_in    = oup_ff;
      lag_in    = lag_ff;
      cmd_pop   = 1'b0;
      mem_rd    = 1'b0;
      mem_addr  = lag_ff;
      mem_we    = 1'b0;
      mem_wsum  = '0;
      mem_wcnt  = '0;
      div_start = 1'b0;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      echo_in   = echo_ff;
      avg_in    = avg_ff;
      tot_in    = tot_ff;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  rra_pkg::OP_FINISH: begin
                     n_in  = cmd.frames;
                     i_in  = '0;
                     st_in = S_ORIG;
                  end
                  rra_pkg::OP_READ: begin
                     lag_in = cmd.lag;
                     st_in  = S_RD;
                  end
                  default: begin
                     lag_in = '0;
                     st_in  = S_CLR;
                  end
               endcase
            end
         end
         S_ORIG: begin
            if (i_ff >= n_ff) begin
               st_in = S_FIN;
            end else begin
               st_in = S_OWAIT;
            end
         end
         S_OWAIT: st_in = S_OCHK;
         S_OCHK: begin
            olow_in = hlow;
            oup_in  = hup;
            k_in    = i_ff;
            st_in   = S_LAG;
         end
         S_LAG: begin
            if (k_ff >= n_ff) begin
               i_in  = i_next;
               st_in = S_ORIG;
            end else begin
               st_in = S_LWAIT;
            end
         end
         S_LWAIT: begin
            lag_in = 10'(k_ff - i_ff);
            st_in  = S_MUL;
         end
         S_MUL: begin
            if ((olow_ff && hlow) || (oup_ff && hup)) begin
               mem_rd = 1'b1;
               st_in  = S_SUM;
            end else begin
               i_in  = i_next;
               st_in = S_ORIG;
            end
         end
         S_SUM: st_in = S_ACC;
         S_ACC: begin
            mem_we = 1'b1;
            if (wide_sum[64] != wide_sum[63]) begin
               mem_wsum = wide_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               mem_wsum = wide_sum[63:0];
            end
            mem_wcnt = (rc_ff == '1) ? rc_ff : rc_ff + 1'b1;
            k_in  = k_ff + 1'b1;
            st_in = S_LAG;
         end
         S_CLR: begin
            mem_we = 1'b1;
            lag_in = lag_ff + 1'b1;
            if (lag_ff == '1) begin
               st_in = S_IDLE;
            end
         end
         S_RD: begin
            mem_rd = 1'b1;
            st_in  = S_RWAIT;
         end
         S_RWAIT: begin
            if (rc_ff == '0) begin
               strobe_in = 1'b1;
               kind_in   = rra_pkg::KIND_READ;
               echo_in   = lag_ff;
               avg_in    = '0;
               tot_in    = '0;
               st_in     = S_IDLE;
            end else begin
               div_start = 1'b1;
               st_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               strobe_in = 1'b1;
               kind_in   = rra_pkg::KIND_READ;
               echo_in   = lag_ff;
               tot_in    = rc_ff;
               if (div_q > 64'sd2147483647) begin
                  avg_in = 32'sh7fffffff;
               end else if (div_q < -64'sd2147483648) begin
                  avg_in = 32'sh80000000;
               end else begin
                  avg_in = div_q[31:0];
               end
               st_in = S_IDLE;
            end
         end
         S_FIN: begin
            strobe_in = 1'b1;
            kind_in   = rra_pkg::KIND_FINISH;
            echo_in   = '0;
            avg_in    = '0;
            tot_in    = '0;
            st_in     = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_CLR;
         lag_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         lag_ff    <= lag_in;
         strobe_ff <= strobe_in;
      end
      n_ff    <= n_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      olow_ff <= olow_in;
      oup_ff  <= oup_in;
      kind_ff <= kind_in;
      echo_ff <= echo_in;
      avg_ff  <= avg_in;
      tot_ff  <= tot_in;
      px_ff   <= signed'(rd_dip_a[47:32]) * signed'(rd_dip_b[47:32]);
      py_ff   <= signed'(rd_dip_a[31:16]) * signed'(rd_dip_b[31:16]);
      pz_ff   <= signed'(rd_dip_a[15:0]) * signed'(rd_dip_b[15:0]);
      dot_ff  <= 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_addr] <= mem_wsum;
         cnt_mem[mem_addr] <= mem_wcnt;
      end
      if (mem_rd) begin
         rs_ff <= sum_mem[mem_addr];
         rc_ff <= cnt_mem[mem_addr];
      end
   end

   rra_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (signed'(rs_ff)),
      .divisor  (rc_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_lag_echo     = echo_ff;
   assign rsp_average      = avg_ff;
   assign rsp_sample_total = tot_ff;

endmodule

>>> hdl/region_restricted_autocorrelation.sv
// Top level of the region-restricted dipole autocorrelation block.
// Busy holds while a command waits and through a finish walk.
// Finish: walks origins by the stride, summing each lag until no height band is shared.
// Read: an empty bin gives zeros without a division, else the bit-serial divider runs.
// Clear: sweeps all 1024 accumulator entries, one a cycle; reset runs the same sweep.
// Results are one-cycle rsp_strobe beats; the receiver cannot stall them.
module region_restricted_autocorrelation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_mu_x,
   input  logic signed [15:0] req_mu_y,
   input  logic signed [15:0] req_mu_z,
   input  logic signed [15:0] req_height,
   input  logic [9:0]         req_read_lag,
   output logic               rsp_strobe,
   output logic               rsp_kind,
   output logic [9:0]         rsp_lag_echo,
   output logic signed [31:0] rsp_average,
   output logic [31:0]        rsp_sample_total,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   rra_pkg::cfg_type              cfg_ff;
   logic                          cmd_valid;
   rra_pkg::cmd_type              cmd;
   logic                          cmd_pop;
   logic                          walking;
   logic [rra_pkg::AddrW-1:0]     rd_addr_a, rd_addr_b;
   logic [47:0]                   rd_dip_a, rd_dip_b;
   logic signed [15:0]            rd_hgt_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stride <= 11'd2;
         cfg_ff.lo_min <= 16'sd0;
         cfg_ff.lo_max <= 16'sd1316;
         cfg_ff.up_min <= 16'sd9702;
         cfg_ff.up_max <= 16'sd11520;
      end else if (csr_write_enable) begin
         case (csr_index)
            rra_pkg::CSR_STRIDE: cfg_ff.stride <= csr_write_data[10:0];
            rra_pkg::CSR_LO_MIN: cfg_ff.lo_min <= csr_write_data;
            rra_pkg::CSR_LO_MAX: cfg_ff.lo_max <= csr_write_data;
            rra_pkg::CSR_UP_MIN: cfg_ff.up_min <= csr_write_data;
            rra_pkg::CSR_UP_MAX: cfg_ff.up_max <= csr_write_data;
            default: ;
         endcase
      end
   end

   rra_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_start    (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_mu_x     (req_mu_x),
      .req_mu_y     (req_mu_y),
      .req_mu_z     (req_mu_z),
      .req_height   (req_height),
      .req_read_lag (req_read_lag),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .walking      (walking),
      .rd_addr_a    (rd_addr_a),
      .rd_addr_b    (rd_addr_b),
      .rd_dip_a     (rd_dip_a),
      .rd_dip_b     (rd_dip_b),
      .rd_hgt_b     (rd_hgt_b)
   );

   rra_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .walking          (walking),
      .cfg              (cfg_ff),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .rd_dip_a         (rd_dip_a),
      .rd_dip_b         (rd_dip_b),
      .rd_hgt_b         (rd_hgt_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_lag_echo     (rsp_lag_echo),
      .rsp_average      (rsp_average),
      .rsp_sample_total (rsp_sample_total)
   );

endmodule

>>> hdl/rra_checker.sv
// Port-level checks for the autocorrelation block, bound to the top level.
module rra_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_op,
   input logic               rsp_strobe,
   input logic               rsp_kind,
   input logic [9:0]         rsp_lag_echo,
   input logic signed [31:0] rsp_average,
   input logic [31:0]        rsp_sample_total
);

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == rra_pkg::OP_READ) |=> busy)
      else $error("read beat did not raise busy");

   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == rra_pkg::OP_FINISH) |=> busy)
      else $error("finish beat did not raise busy");

   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == rra_pkg::KIND_FINISH) |->
      (rsp_lag_echo == '0 && rsp_average == '0 && rsp_sample_total == '0))
      else $error("finish result carries data");

   a_empty_avg: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_sample_total == '0) |-> rsp_average == '0)
      else $error("nonzero average with no samples");

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held");

endmodule

bind region_restricted_autocorrelation rra_checker u_rra_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_op           (req_op),
   .rsp_strobe       (rsp_strobe),
   .rsp_kind         (rsp_kind),
   .rsp_lag_echo     (rsp_lag_echo),
   .rsp_average      (rsp_average),
   .rsp_sample_total (rsp_sample_total)
);

>>> test/region_restricted_autocorrelation_tb.sv
// Self-checking testbench for the region-restricted dipole autocorrelation block.
module region_restricted_autocorrelation_tb;

   localparam int STALL_LIMIT = 100000;
   localparam int IDLE_PAUSE  = 1100;

   typedef struct packed {
      logic               kind;
      logic [9:0]         lag;
      logic signed [31:0] avg;
      logic [31:0]        total;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
      logic signed [15:0] h;
      logic [9:0]         lag;
      logic               typed;
      rsp_beat_type       beat;
   } stim_row_type;

   localparam logic signed [15:0] NEG = 16'sh8000;
   localparam logic signed [15:0] POS = 16'sh7FFF;
   localparam rsp_beat_type NONE    = '{rra_pkg::KIND_FINISH, 10'd0, 32'sd0, 32'd0};
   localparam rsp_beat_type FIN     = '{rra_pkg::KIND_FINISH, 10'd0, 32'sd0, 32'd0};
   localparam rsp_beat_type EMPTY0  = '{rra_pkg::KIND_READ, 10'd0, 32'sd0, 32'd0};
   localparam rsp_beat_type EMPTY_T = '{rra_pkg::KIND_READ, 10'd1023, 32'sd0, 32'd0};
   localparam rsp_beat_type CLAMP0  = '{rra_pkg::KIND_READ, 10'd0, 32'sh7FFF_FFFF, 32'd1};
   localparam rsp_beat_type CLAMP1  = '{rra_pkg::KIND_READ, 10'd1, 32'sh7FFF_FFFF, 32'd1};

   localparam int DIR_ROWS = 25;
   localparam stim_row_type DIR_TAB [DIR_ROWS] = '{
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd0, 1'b1, EMPTY0},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd1023, 1'b1, EMPTY_T},
      '{rra_pkg::OP_FINISH, 0, 0, 0, 0, 10'd0, 1'b1, FIN},
      '{rra_pkg::OP_LOAD,   NEG, NEG, NEG, 16'sd0, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   NEG, NEG, NEG, 16'sd1316, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_FINISH, 0, 0, 0, 0, 10'd0, 1'b1, FIN},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd0, 1'b1, CLAMP0},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd1, 1'b1, CLAMP1},
      '{rra_pkg::OP_CLEAR,  0, 0, 0, 0, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd0, 1'b1, EMPTY0},
      '{rra_pkg::OP_LOAD,   POS, NEG, POS, 16'sd9702, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   NEG, POS, NEG, 16'sd11520, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   POS, POS, POS, POS, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   -16'sd1, 0, 16'sd1, NEG, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   0, 0, 0, -16'sd1, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   16'sd1, 16'sd1, 16'sd1, 16'sd1, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_FINISH, 0, 0, 0, 0, 10'd0, 1'b1, FIN},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd1, 1'b0, NONE},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd2, 1'b0, NONE},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd4, 1'b0, NONE},
      '{rra_pkg::OP_LOAD,   16'sh4000, -16'sh4000, 16'sh2000, 16'sd5, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_CLEAR,  0, 0, 0, 0, 10'd0, 1'b0, NONE},
      '{rra_pkg::OP_FINISH, 0, 0, 0, 0, 10'd0, 1'b1, FIN},
      '{rra_pkg::OP_READ,   0, 0, 0, 0, 10'd0, 1'b0, NONE}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic signed [15:0] req_mu_x;
   logic signed [15:0] req_mu_y;
   logic signed [15:0] req_mu_z;
   logic signed [15:0] req_height;
   logic [9:0]         req_read_lag;
   logic               rsp_strobe;
   logic               rsp_kind;
   logic [9:0]         rsp_lag_echo;
   logic signed [31:0] rsp_average;
   logic [31:0]        rsp_sample_total;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [15:0]        csr_write_data;

   region_restricted_autocorrelation DUT (.*);

   // predictor state
   logic signed [15:0] dip_x [rra_pkg::MaxFrames];
   logic signed [15:0] dip_y [rra_pkg::MaxFrames];
   logic signed [15:0] dip_z [rra_pkg::MaxFrames];
   logic signed [15:0] heights [rra_pkg::MaxFrames];
   int unsigned        fill;
   logic signed [63:0] lag_sum [rra_pkg::MaxFrames];
   logic [31:0]        lag_cnt [rra_pkg::MaxFrames];
   logic [10:0]        cfg_stride;
   logic signed [15:0] cfg_lo_min, cfg_lo_max, cfg_up_min, cfg_up_max;

   rsp_beat_type beats_due [$];
   int           fail_count;
   int           stall_cycles;
   int           item_count;
   bit           steady;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit in_lo(logic signed [15:0] h);
      return h >= cfg_lo_min && h <= cfg_lo_max;
   endfunction

   function automatic bit in_up(logic signed [15:0] h);
      return h >= cfg_up_min && h <= cfg_up_max;
   endfunction

   function automatic logic signed [63:0] dot(int a, int b);
      return (64'(dip_x[a]) * 64'(dip_x[b])) + (64'(dip_y[a]) * 64'(dip_y[b]))
             + (64'(dip_z[a]) * 64'(dip_z[b]));
   endfunction

   task automatic add_sample(int l, logic signed [63:0] d);
      logic signed [64:0] t;
      t = {lag_sum[l][63], lag_sum[l]} + {d[63], d};
      if (t[64] != t[63])
         lag_sum[l] = t[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      else
         lag_sum[l] = t[63:0];
      if (lag_cnt[l] != 32'hFFFF_FFFF)
         lag_cnt[l]++;
   endtask

   task automatic walk_molecule();
      int  stride;
      bit  ol, ou;
      stride = (cfg_stride == 0) ? 1 : int'(cfg_stride);
      for (int i = 0; i < fill; i += stride) begin
         ol = in_lo(heights[i]);
         ou = in_up(heights[i]);
         for (int k = i; k < fill; k++) begin
            if (!((ol && in_lo(heights[k])) || (ou && in_up(heights[k]))))
               break;
            add_sample(k - i, dot(i, k));
         end
      end
      fill = 0;
   endtask

   task automatic autocorr_step(input stim_row_type s, output bit has,
                                output rsp_beat_type r);
      logic signed [63:0] q;
      has = 1'b0;
      r = NONE;
      case (s.op)
         rra_pkg::OP_LOAD: begin
            if (fill < rra_pkg::MaxFrames) begin
               dip_x[fill] = s.mx;
               dip_y[fill] = s.my;
               dip_z[fill] = s.mz;
               heights[fill] = s.h;
               fill++;
            end
         end
         rra_pkg::OP_FINISH: begin
            walk_molecule();
            has = 1'b1;
         end
         rra_pkg::OP_READ: begin
            q = 0;
            if (lag_cnt[s.lag] != 0)
               q = lag_sum[s.lag] / $signed({32'd0, lag_cnt[s.lag]});
            if (q > 64'sd2147483647)
               q = 64'sd2147483647;
            if (q < -64'sd2147483648)
               q = -64'sd2147483648;
            r = '{rra_pkg::KIND_READ, s.lag, q[31:0], lag_cnt[s.lag]};
            has = 1'b1;
         end
         default: begin
            for (int i = 0; i < rra_pkg::MaxFrames; i++) begin
               lag_sum[i] = 0;
               lag_cnt[i] = 0;
            end
         end
      endcase
   endtask

   task automatic send(input stim_row_type s);
      bit           has;
      rsp_beat_type r;
      if (!steady && $urandom_range(99) < 20) begin
         @(negedge clock) start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_op       <= s.op;
      req_mu_x     <= s.mx;
      req_mu_y     <= s.my;
      req_mu_z     <= s.mz;
      req_height   <= s.h;
      req_read_lag <= s.lag;
      do @(posedge clock); while (busy);
      autocorr_step(s, has, r);
      if (s.typed)
         r = s.beat;
      if (has)
         beats_due.insert(beats_due.size(), r);
      item_count++;
   endtask

   task automatic settle();
      @(negedge clock) start <= 1'b0;
      wait (beats_due.size() == 0);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         rra_pkg::CSR_STRIDE: cfg_stride = val[10:0];
         rra_pkg::CSR_LO_MIN: cfg_lo_min = val;
         rra_pkg::CSR_LO_MAX: cfg_lo_max = val;
         rra_pkg::CSR_UP_MIN: cfg_up_min = val;
         default:             cfg_up_max = val;
      endcase
   endtask

   task automatic set_bands(logic [15:0] stride, logic [15:0] lo_min, logic [15:0] lo_max,
                            logic [15:0] up_min, logic [15:0] up_max);
      settle();
      write_csr(rra_pkg::CSR_STRIDE, stride);
      write_csr(rra_pkg::CSR_LO_MIN, lo_min);
      write_csr(rra_pkg::CSR_LO_MAX, lo_max);
      write_csr(rra_pkg::CSR_UP_MIN, up_min);
      write_csr(rra_pkg::CSR_UP_MAX, up_max);
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_height(bit upper);
      int lo, hi;
      lo = upper ? int'(cfg_up_min) : int'(cfg_lo_min);
      hi = upper ? int'(cfg_up_max) : int'(cfg_lo_max);
      if (lo > hi || $urandom_range(99) < 10)
         return 16'($urandom());
      return 16'(lo + int'($urandom_range(hi - lo)));
   endfunction

   function automatic stim_row_type rand_row(logic [1:0] op);
      stim_row_type s;
      s = '{op, 16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
            10'($urandom()), 1'b0, NONE};
      if ($urandom_range(3) != 0)
         s.lag = 10'($urandom_range(40));
      return s;
   endfunction

   task automatic random_traffic(int target);
      stim_row_type s;
      int           n, stop_at;
      bit           upper;
      stop_at = item_count + target;
      while (item_count < stop_at) begin
         steady = item_count >= 300 && item_count < 450;
         n = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 24);
         upper = 1'($urandom_range(1));
         for (int f = 0; f < n; f++) begin
            s = rand_row(rra_pkg::OP_LOAD);
            s.h = pick_height(upper);
            send(s);
            if ($urandom_range(99) < 4)
               send(rand_row(rra_pkg::OP_READ));
         end
         send(rand_row(rra_pkg::OP_FINISH));
         repeat ($urandom_range(1, 3)) send(rand_row(rra_pkg::OP_READ));
         if ($urandom_range(99) < 5)
            send(rand_row(rra_pkg::OP_CLEAR));
      end
      steady = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = rra_pkg::OP_LOAD;
      req_mu_x         = '0;
      req_mu_y         = '0;
      req_mu_z         = '0;
      req_height       = '0;
      req_read_lag     = '0;
      csr_write_enable = 1'b0;
      csr_index        = rra_pkg::CSR_STRIDE;
      csr_write_data   = '0;
      fill             = 0;
      fail_count       = 0;
      item_count       = 0;
      steady           = 1'b0;
      cfg_stride       = 11'd2;
      cfg_lo_min       = 16'sd0;
      cfg_lo_max       = 16'sd1316;
      cfg_up_min       = 16'sd9702;
      cfg_up_max       = 16'sd11520;
      for (int i = 0; i < rra_pkg::MaxFrames; i++) begin
         lag_sum[i] = 0;
         lag_cnt[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send(DIR_TAB[i]);

      set_bands(16'd1, 16'h8000, 16'h0000, 16'h0001, 16'h7FFF);
      random_traffic(200);
      set_bands(16'd0, 16'd100, -16'd100, -16'd500, 16'd500);
      random_traffic(200);
      set_bands(16'd1024, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      random_traffic(200);
      set_bands(16'd5, 16'd0, 16'd1316, 16'd9702, 16'd11520);
      random_traffic(200);

      @(negedge clock) start <= 1'b0;
      wait (beats_due.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_kind, rsp_lag_echo, rsp_average, rsp_sample_total};
         if (beats_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected beat kind=%0d lag=%0d avg=%0d total=%0d",
                        got.kind, got.lag, got.avg, got.total);
         end else begin
            want = beats_due.pop_front();
            if (got != want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           want.kind, want.lag, want.avg, want.total,
                           got.kind, got.lag, got.avg, got.total);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

endmodule
